// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared immediate-style wrappers around concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcu_pkg
// shared widths, constants and control types of the binomial coefficient unit
// ----------------------------------------------------------------------------
`default_nettype none

package bcu_pkg;

   localparam int FIELD_W   = 7;
   localparam int VALUE_W   = 64;
   localparam int PROD_W    = VALUE_W + FIELD_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   localparam logic [DIV_CNT_W-1:0] DIV_LAST_IDX = DIV_CNT_W'(PROD_W - 1);
   localparam logic [VALUE_W-1:0]   VALUE_SAT    = {VALUE_W{1'b1}};

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic update;
      logic saturate;
      logic emit;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic loop_done;
      logic div_last;
      logic overflow;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/binomial_coefficient_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_unit
// C(n,k) as a 64-bit unsigned value by the multiplicative method
// ----------------------------------------------------------------------------
// One request carries n (req_set_size) and k (req_subset_size); one response
// returns C(n,k) on rsp_combinations. k above n gives 0; a true value beyond
// 64 bits gives all ones. The unit works on one request at a time: after
// load, each loop step j = 1..min(k, n-k) passes a check state that also
// forms the 64x7 product, the steps of the radix-2 restoring divider and an
// update state. After the last loop step a final check leads to the output;
// the loop ends early when the value overflows.
// The result sits in its own output register, so a new request is taken
// while the previous response is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bcu_pkg::FIELD_W-1:0]   req_set_size,
   input  wire logic [bcu_pkg::FIELD_W-1:0]   req_subset_size,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [bcu_pkg::VALUE_W-1:0]   rsp_combinations
);

   // command and status between the sequencer and the datapath
   bcu_pkg::ctrl_cmd_type  cmd;
   bcu_pkg::dp_status_type status;

   // sequencer: loop control and handshakes
   bcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: operand capture, multiplier, divider, output register
   bcu_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .set_size     (req_set_size),
      .subset_size  (req_subset_size),
      .combinations (rsp_combinations)
   );

endmodule

`default_nettype wire

// ===== sv/bcu_datapath.sv =====
// ----------------------------------------------------------------------------
// bcu_datapath
// operand registers, 64x7 multiplier and radix-2 restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bcu_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bcu_pkg::ctrl_cmd_type             cmd,
   output bcu_pkg::dp_status_type                 status,
   input  wire logic [bcu_pkg::FIELD_W-1:0]       set_size,
   input  wire logic [bcu_pkg::FIELD_W-1:0]       subset_size,
   output logic      [bcu_pkg::VALUE_W-1:0]       combinations
);

   localparam int FieldW = bcu_pkg::FIELD_W;
   localparam int ValueW = bcu_pkg::VALUE_W;
   localparam int ProdW  = bcu_pkg::PROD_W;
   localparam int CntW   = bcu_pkg::DIV_CNT_W;

   logic [FieldW-1:0] m_ff, m_in;
   logic [FieldW-1:0] j_ff, j_in;
   logic [FieldW-1:0] kk_ff, kk_in;
   logic [ValueW-1:0] value_ff, value_in;
   logic [ProdW-1:0]  dq_ff, dq_in;
   logic [FieldW-1:0] rem_ff, rem_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [ValueW-1:0] out_ff, out_in;

   logic [FieldW-1:0] n_minus_k;
   logic [FieldW-1:0] eff_k;
   logic              k_gt_n;
   logic [ProdW-1:0]  prod;
   logic [FieldW:0]   trial;
   logic              trial_ge;

   // k above n gives zero, otherwise take the smaller side
   assign k_gt_n    = subset_size > set_size;
   assign n_minus_k = set_size - subset_size;
   assign eff_k     = (n_minus_k < subset_size) ? n_minus_k : subset_size;

   assign prod = ProdW'(value_ff) * ProdW'(m_ff);

   // one restoring step: shift in the next dividend bit
   assign trial    = {rem_ff, dq_ff[ProdW-1]};
   assign trial_ge = trial >= {1'b0, j_ff};

   always_comb begin
      m_in     = m_ff;
      j_in     = j_ff;
      kk_in    = kk_ff;
      value_in = value_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         m_in     = set_size;
         j_in     = FieldW'(1);
         kk_in    = k_gt_n ? '0 : eff_k;
         value_in = k_gt_n ? '0 : ValueW'(1);
      end
      if (cmd.mul) begin
         dq_in  = prod;
         rem_in = '0;
         cnt_in = bcu_pkg::DIV_LAST_IDX;
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? FieldW'(trial - {1'b0, j_ff}) : FieldW'(trial);
         dq_in  = {dq_ff[ProdW-2:0], trial_ge};
         cnt_in = cnt_ff - CntW'(1);
      end
      if (cmd.update) begin
         value_in = dq_ff[ValueW-1:0];
         m_in     = m_ff - FieldW'(1);
         j_in     = j_ff + FieldW'(1);
      end
      if (cmd.saturate) begin
         value_in = bcu_pkg::VALUE_SAT;
      end
      if (cmd.emit) begin
         out_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      j_ff     <= j_in;
      kk_ff    <= kk_in;
      value_ff <= value_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      out_ff   <= out_in;
   end

   assign status.loop_done = j_ff > kk_ff;
   assign status.div_last  = cnt_ff == '0;
   assign status.overflow  = dq_ff[ProdW-1:ValueW] != '0;
   assign combinations     = out_ff;

   // every step divides exactly
   `ASSERT_SAME(a_exact_div, clock, reset, cmd.update || cmd.saturate, rem_ff == '0,
      "inexact division step")
   // a partial coefficient is never zero
   `ASSERT_NEXT(a_value_nonzero, clock, reset, cmd.update, value_ff != '0,
      "zero partial coefficient")
   // saturation only on a quotient past 64 bits
   `ASSERT_SAME(a_sat_cause, clock, reset, cmd.saturate, status.overflow,
      "saturation without overflow")

endmodule

`default_nettype wire

// ===== sv/bcu_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcu_ctrl
// sequencer for the multiply-divide loop and the result handshake
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bcu_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bcu_pkg::ctrl_cmd_type       cmd,
   input  wire bcu_pkg::dp_status_type status
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StCheck = 3'd1;
   localparam logic [2:0] StDiv   = 3'd2;
   localparam logic [2:0] StUpd   = 3'd3;
   localparam logic [2:0] StDone  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != StIdle;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         StIdle: begin
            if (req_take) begin
               cmd.load = 1'b1;
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (status.loop_done) begin
               state_in = StDone;
            end else begin
               cmd.mul  = 1'b1;
               state_in = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = StUpd;
            end
         end
         StUpd: begin
            if (status.overflow) begin
               cmd.saturate = 1'b1;
               state_in     = StDone;
            end else begin
               cmd.update = 1'b1;
               state_in   = StCheck;
            end
         end
         StDone: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // accepted request starts the loop check
   `ASSERT_NEXT(a_load_to_check, clock, reset, req_take, state_ff == StCheck,
      "request accepted without loop start")
   // division runs to its last step and then hands over to the update state
   `ASSERT_NEXT(a_div_to_upd, clock, reset, state_ff == StDiv && status.div_last,
      state_ff == StUpd, "divider did not hand over")
   // finished result shows up on the output
   `ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff,
      "result not presented")

endmodule

`default_nettype wire
